[rtl/hq_pkg.sv]
package hq_pkg;

	// Fixed widths of the channel fields
	localparam int KEY_PORT_W = 32;
	localparam int COUNT_W    = 11;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} hq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} hq_status_t;

	typedef struct packed {
		hq_op_t                  cmd;
		logic [KEY_PORT_W-1:0]   value;
	} hq_req_t;

	typedef struct packed {
		logic [KEY_PORT_W-1:0]   popped_value;
		logic [KEY_PORT_W-1:0]   min_value;
		logic [COUNT_W-1:0]      count;
		logic                    is_empty;
		hq_status_t              status;
	} hq_rsp_t;

	// Datapath operation issued by the controller each cycle
	typedef enum logic [3:0] {
		DP_NOP,
		DP_START,
		DP_PUT,
		DP_UP_READ,
		DP_UP_STEP,
		DP_POP_READ,
		DP_POP_TAKE,
		DP_DN_READ,
		DP_DN_STEP,
		DP_ROOT_READ,
		DP_LOAD_RES
	} hq_dp_op_t;

	// Datapath flags seen by the controller
	typedef struct packed {
		logic refuse;     // word at the input cannot be served
		logic pop;        // word at the input is a pop
		logic at_root;    // sift position is the root
		logic leaf;       // sift position has no children
		logic up_move;    // carried key is below its parent
		logic down_move;  // a child is below the carried key
	} hq_sts_t;

endpackage

[rtl/hq_stream_if.sv]
interface hq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/hq_ctrl.sv]
module hq_ctrl
	import hq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  hq_sts_t   sts,
	output hq_dp_op_t op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_POP_RD,
		S_POP_TAKE,
		S_DN_CHK,
		S_DN_CMP,
		S_ROOT_RD,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   load_res;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign load_res  = (state_q == S_RESULT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		op      = DP_NOP;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op = DP_START;
					priority if (sts.refuse) state_d = S_ROOT_RD;
					else if (sts.pop)        state_d = S_POP_RD;
					else                     state_d = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				if (sts.at_root) begin
					op      = DP_PUT;
					state_d = S_ROOT_RD;
				end else begin
					op      = DP_UP_READ;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_move) begin
					op      = DP_UP_STEP;
					state_d = S_UP_CHK;
				end else begin
					op      = DP_PUT;
					state_d = S_ROOT_RD;
				end
			end
			S_POP_RD: begin
				op      = DP_POP_READ;
				state_d = S_POP_TAKE;
			end
			S_POP_TAKE: begin
				op      = DP_POP_TAKE;
				state_d = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (sts.leaf) begin
					op      = DP_PUT;
					state_d = S_ROOT_RD;
				end else begin
					op      = DP_DN_READ;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (sts.down_move) begin
					op      = DP_DN_STEP;
					state_d = S_DN_CHK;
				end else begin
					op      = DP_PUT;
					state_d = S_ROOT_RD;
				end
			end
			S_ROOT_RD: begin
				op      = DP_ROOT_READ;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (load_res) begin
					op      = DP_LOAD_RES;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/hq_dp.sv]
module hq_dp
	import hq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  hq_dp_op_t op,
	input  hq_req_t   req_data,
	output hq_sts_t   sts,
	output hq_rsp_t   rsp_data
);

	localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Slot k of the heap lives at address k-1
	logic [KW-1:0] mem [CAPACITY];

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [KW-1:0] key_q;
	logic [KW-1:0] popped_q;
	hq_status_t    status_q;
	logic [KW-1:0] rd_a_q;
	logic [KW-1:0] rd_b_q;
	hq_rsp_t       rsp_q;

	logic          full;
	logic          empty;
	logic [CW-1:0] parent_slot;
	logic [CW:0]   left_slot;
	logic [CW:0]   right_slot;
	logic          right_ok;
	logic          lt_l;
	logic          lt_r;
	logic [KW-1:0] cand;
	logic [CW-1:0] child_slot;
	logic [KW-1:0] child_key;

	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [KW-1:0] wr_data;
	logic          rd_a_en;
	logic [IW-1:0] rd_a_idx;
	logic          rd_b_en;
	logic [IW-1:0] rd_b_idx;

	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);

	assign parent_slot = pos_q >> 1;
	assign left_slot   = {pos_q, 1'b0};
	assign right_slot  = {pos_q, 1'b1};
	assign right_ok    = (right_slot <= {1'b0, cnt_q});

	// Smaller child wins only when strictly below; left on a tie
	assign lt_l       = (rd_a_q < key_q);
	assign cand       = lt_l ? rd_a_q : key_q;
	assign lt_r       = right_ok && (rd_b_q < cand);
	assign child_slot = lt_r ? CW'(right_slot) : CW'(left_slot);
	assign child_key  = lt_r ? rd_b_q : rd_a_q;

	assign sts.pop       = (req_data.cmd == OP_POP);
	assign sts.refuse    = sts.pop ? empty : full;
	assign sts.at_root   = (pos_q == CW'(1));
	assign sts.leaf      = (pos_q > (cnt_q >> 1));
	assign sts.up_move   = (key_q < rd_a_q);
	assign sts.down_move = lt_l || lt_r;

	assign rsp_data = rsp_q;

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = IW'(pos_q - 1'b1);
		wr_data  = key_q;
		rd_a_en  = 1'b0;
		rd_a_idx = '0;
		rd_b_en  = 1'b0;
		rd_b_idx = IW'(left_slot);
		unique case (op)
			DP_PUT: begin
				wr_en = 1'b1;
			end
			DP_UP_READ: begin
				rd_a_en  = 1'b1;
				rd_a_idx = IW'(parent_slot - 1'b1);
			end
			DP_UP_STEP: begin
				wr_en   = 1'b1;
				wr_data = rd_a_q;
			end
			DP_POP_READ: begin
				rd_a_en  = 1'b1;
				rd_b_en  = 1'b1;
				rd_b_idx = IW'(cnt_q - 1'b1);
			end
			DP_DN_READ: begin
				rd_a_en  = 1'b1;
				rd_a_idx = IW'(left_slot - 1'b1);
				rd_b_en  = 1'b1;
			end
			DP_DN_STEP: begin
				wr_en   = 1'b1;
				wr_data = child_key;
			end
			DP_ROOT_READ: begin
				rd_a_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		if (rd_a_en)
			rd_a_q <= mem[rd_a_idx];
		if (rd_b_en)
			rd_b_q <= mem[rd_b_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (op == DP_START && !sts.pop && !full)
				cnt_q <= cnt_q + 1'b1;
			else if (op == DP_POP_TAKE)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			DP_START: begin
				key_q    <= req_data.value[KW-1:0];
				popped_q <= '0;
				pos_q    <= cnt_q + 1'b1;
				if (sts.pop)
					status_q <= empty ? ST_EMPTY : ST_OK;
				else
					status_q <= full ? ST_FULL : ST_OK;
			end
			DP_UP_STEP: pos_q <= parent_slot;
			DP_POP_TAKE: begin
				popped_q <= rd_a_q;
				key_q    <= rd_b_q;
				pos_q    <= CW'(1);
			end
			DP_DN_STEP: pos_q <= child_slot;
			DP_LOAD_RES: begin
				rsp_q.popped_value <= KEY_PORT_W'(popped_q);
				rsp_q.min_value    <= empty ? '0 : KEY_PORT_W'(rd_a_q);
				rsp_q.count        <= COUNT_W'(cnt_q);
				rsp_q.is_empty     <= empty;
				rsp_q.status       <= status_q;
			end
			default: ;
		endcase
	end

endmodule

[rtl/min_heap_priority_queue.sv]
// Binary min-heap priority queue with one request and one response channel.
// req carries a word {cmd, value}: cmd OP_INSERT adds value (low KEY_WIDTH
// bits), cmd OP_POP removes the smallest key. Every request gives exactly
// one rsp word: popped key, new minimum, count, empty flag and a status.
// Pop on an empty heap or insert into a full one changes nothing and is
// reported as ST_EMPTY or ST_FULL.
// One request is worked at a time. Each level that the key moves costs a
// read of the key store (registered read data) followed by a compare and a
// write. A refused request skips the sift and goes straight to the root read.
// The result sits in an output register; req.ready rises as soon as it is
// loaded, so the next request is taken while the receiver stalls. Work on
// that next request halts before its own result until rsp is taken.
// Reset (arst_n low) empties the heap at once: the count clears and the
// key store is left as is, since no slot beyond the count is ever used.
module min_heap_priority_queue
	import hq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	hq_stream_if.sink   req,
	hq_stream_if.source rsp
);

	hq_dp_op_t op;
	hq_sts_t   sts;
	hq_rsp_t   rsp_data;
	hq_req_t   req_data;

	assign req_data    = req.payload;
	assign rsp.payload = rsp_data;

	// Sequence the sift: one level per read/compare pair
	hq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.op        (op)
	);

	// Key store, count, sift position and the result register
	hq_dp #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.req_data (req_data),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

	// An empty heap reports no minimum and no entries
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.is_empty |->
			rsp.payload.min_value == '0 && rsp.payload.count == '0)
		else $error("empty heap reports a minimum or entries");

	// A refused request never hands out a key
	a_refused_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status != ST_OK |->
			rsp.payload.popped_value == '0)
		else $error("refused request returned a key");

	// A pop refused for emptiness must see an empty heap
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status == ST_EMPTY |-> rsp.payload.is_empty)
		else $error("pop refused on a non-empty heap");

	// Only one request is worked at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in work");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb
	import hq_pkg::*;
();

	localparam int HEAP_CAP = 1024;
	localparam int KEY_W = 32;
	localparam logic [63:0] KEY_MASK = (64'd1 << KEY_W) - 64'd1;
	// Longest correct quiet stretch: the long receiver hold plus a long gap and a
	// worst-case sift; take it several times over.
	localparam int RSP_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct {
		hq_op_t op;
		logic [KEY_PORT_W-1:0] key;
		bit typed;
		hq_rsp_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	hq_stream_if #(.payload_t(hq_req_t)) req_ch ();
	hq_stream_if #(.payload_t(hq_rsp_t)) rsp_ch ();

	min_heap_priority_queue #(
		.CAPACITY(HEAP_CAP),
		.KEY_WIDTH(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow heap: one-based keys and the number of entries held.
	logic [KEY_PORT_W-1:0] heap_keys [1:HEAP_CAP];
	int heap_size = 0;

	// Responses owed by the block, oldest first.
	hq_rsp_t rsp_due[$];

	int errors = 0;
	int idle_cycles = 0;
	bit tx_calm = 0;
	bit rx_calm = 0;
	bit rsp_hold_req = 0;
	bit pressure_sent = 0;
	stim_row_t directed[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one request word to the shadow heap and return the response it owes.
	// Sift up stops on equal keys; sift down moves only to a strictly smaller
	// child and keeps the left child when both children tie.
	function automatic hq_rsp_t heap_apply(hq_op_t op, logic [KEY_PORT_W-1:0] raw_key);
		hq_rsp_t r;
		logic [KEY_PORT_W-1:0] key;
		logic [KEY_PORT_W-1:0] tmp;
		int pos;
		int best;
		int kid;
		bit moving;
		r = '0;
		r.status = ST_OK;
		key = raw_key & KEY_MASK[KEY_PORT_W-1:0];
		if (op == OP_INSERT) begin
			if (heap_size >= HEAP_CAP) begin
				r.status = ST_FULL;
			end else begin
				heap_size++;
				heap_keys[heap_size] = key;
				pos = heap_size;
				while (pos > 1 && heap_keys[pos] < heap_keys[pos / 2]) begin
					tmp = heap_keys[pos];
					heap_keys[pos] = heap_keys[pos / 2];
					heap_keys[pos / 2] = tmp;
					pos = pos / 2;
				end
			end
		end else if (heap_size == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.popped_value = heap_keys[1];
			heap_keys[1] = heap_keys[heap_size];
			heap_size--;
			pos = 1;
			moving = 1'b1;
			while (moving && pos <= heap_size / 2) begin
				best = pos;
				kid = 2 * pos;
				if (heap_keys[kid] < heap_keys[best])
					best = kid;
				if (kid + 1 <= heap_size && heap_keys[kid + 1] < heap_keys[best])
					best = kid + 1;
				if (best == pos) begin
					moving = 1'b0;
				end else begin
					tmp = heap_keys[pos];
					heap_keys[pos] = heap_keys[best];
					heap_keys[best] = tmp;
					pos = best;
				end
			end
		end
		r.min_value = heap_size > 0 ? heap_keys[1] : '0;
		r.count = heap_size[COUNT_W-1:0];
		r.is_empty = heap_size == 0;
		return r;
	endfunction

	// Idle length: mostly none, some short, a few long; none while calm.
	function automatic int pick_gap(bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(12, 50);
	endfunction

	// Keys: extremes and a narrow range often, so ties show up in the sifts.
	function automatic logic [KEY_PORT_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		if (roll < 5)
			return $urandom_range(0, 15);
		return $urandom;
	endfunction

	function automatic stim_row_t row(hq_op_t op, logic [KEY_PORT_W-1:0] key,
			bit typed = 1'b0, logic [KEY_PORT_W-1:0] pv = '0,
			logic [KEY_PORT_W-1:0] mv = '0, int cnt = 0, hq_status_t st = ST_OK);
		stim_row_t s;
		s.op = op;
		s.key = key;
		s.typed = typed;
		s.want.popped_value = pv;
		s.want.min_value = mv;
		s.want.count = cnt[COUNT_W-1:0];
		s.want.is_empty = cnt == 0;
		s.want.status = st;
		return s;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(stim_row_t s);
		directed.insert(directed.size(), s);
	endfunction

	// Offer one request word after a random gap and hold it until taken.
	// Called at a rising edge; valid gets a single assignment per edge.
	task automatic send_word(hq_op_t op, logic [KEY_PORT_W-1:0] key, bit typed,
			hq_rsp_t want);
		hq_rsp_t predicted;
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= '{cmd: op, value: key};
		do
			@(posedge clk);
		while (!req_ch.ready);
		// Word accepted at this edge: advance the shadow heap.
		predicted = heap_apply(op, key);
		rsp_due.insert(rsp_due.size(), typed ? want : predicted);
	endtask

	// One random phase: insert_pct picks the mix. With until_full set, run on
	// until the heap is at capacity as well.
	task automatic run_phase(int items, int insert_pct, bit until_full);
		int k;
		hq_op_t op;
		k = 0;
		while (k < items || (until_full && heap_size < HEAP_CAP)) begin
			if (k % 64 == 0)
				tx_calm = $urandom_range(0, 3) == 0;
			// Halfway up, hold the receiver off long enough to back up the input.
			if (!pressure_sent && heap_size == HEAP_CAP / 2) begin
				rsp_hold_req = 1'b1;
				pressure_sent = 1'b1;
			end
			op = $urandom_range(0, 99) < insert_pct ? OP_INSERT : OP_POP;
			send_word(op, pick_key(), 1'b0, '0);
			k++;
		end
	endtask

	// Reset once, at the start.
	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request side: directed table, then random phases, then drain and report.
	initial begin
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		@(posedge clk);

		// Pop on empty, the key extremes and tied keys first.
		add_row(row(OP_POP, '1, 1'b1, '0, '0, 0, ST_EMPTY));
		add_row(row(OP_INSERT, '1, 1'b1, '0, '1, 1));
		add_row(row(OP_INSERT, '0, 1'b1, '0, '0, 2));
		add_row(row(OP_INSERT, '0, 1'b1, '0, '0, 3));
		add_row(row(OP_POP, 32'h1234_5678, 1'b1, '0, '0, 2));
		add_row(row(OP_POP, '0, 1'b1, '0, '1, 1));
		add_row(row(OP_POP, '1, 1'b1, '1, '0, 0));
		add_row(row(OP_POP, '0, 1'b1, '0, '0, 0, ST_EMPTY));
		add_row(row(OP_INSERT, 32'd7));
		add_row(row(OP_INSERT, 32'd5));
		add_row(row(OP_INSERT, 32'd5));
		add_row(row(OP_INSERT, 32'd5));
		add_row(row(OP_INSERT, 32'h8000_0000));
		add_row(row(OP_INSERT, 32'h7FFF_FFFF));
		add_row(row(OP_INSERT, 32'd1));
		add_row(row(OP_INSERT, 32'd5));
		add_row(row(OP_INSERT, 32'hAAAA_AAAA));
		add_row(row(OP_INSERT, 32'h5555_5555));
		add_row(row(OP_POP, 32'hAAAA_AAAA));
		add_row(row(OP_POP, 32'h5555_5555));
		add_row(row(OP_POP, '0));
		add_row(row(OP_POP, '1));
		add_row(row(OP_POP, '0));
		add_row(row(OP_POP, '0));
		add_row(row(OP_INSERT, 32'd3));
		foreach (directed[i])
			send_word(directed[i].op, directed[i].key, directed[i].typed, directed[i].want);

		// Churn near empty, fill to capacity, bounce off full, then drain part way.
		run_phase(30, 50, 1'b0);
		run_phase(0, 98, 1'b1);
		run_phase(30, 60, 1'b0);
		run_phase(40, 25, 1'b0);

		req_ch.valid <= 1'b0;
		while (rsp_due.size() > 0)
			@(posedge clk);
		// Catch any stray response word past the last expected one.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("min_heap_priority_queue regression: pass");
		else
			$display("min_heap_priority_queue regression: fail");
		$finish;
	end

	// Response side: random back-pressure, re-rolled calm stretches, and the
	// one long hold that fills the block and stalls its input.
	initial begin
		int gap;
		int cyc;
		rsp_ch.ready <= 1'b0;
		cyc = 0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		rsp_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 256 == 0)
				rx_calm = $urandom_range(0, 3) == 0;
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				gap = pick_gap(rx_calm);
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Check every response word against the oldest one owed.
	always @(posedge clk) begin
		hq_rsp_t want;
		hq_rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected response word %h", $time, got);
				errors++;
			end else begin
				want = rsp_due.pop_front();
				if (got.popped_value !== want.popped_value) begin
					$display("%0t: popped_value expected %h actual %h",
						$time, want.popped_value, got.popped_value);
					errors++;
				end
				if (got.min_value !== want.min_value) begin
					$display("%0t: min_value expected %h actual %h",
						$time, want.min_value, got.min_value);
					errors++;
				end
				if (got.count !== want.count) begin
					$display("%0t: count expected %0d actual %0d",
						$time, want.count, got.count);
					errors++;
				end
				if (got.is_empty !== want.is_empty) begin
					$display("%0t: is_empty expected %b actual %b",
						$time, want.is_empty, got.is_empty);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("min_heap_priority_queue regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
